FILE: hdl/box_smooth_3x3_core_macros.svh
// Assertion macros used by the box smoothing top level.
`ifndef BOX_SMOOTH_3X3_CORE_MACROS_SVH
`define BOX_SMOOTH_3X3_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BS3_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BS3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/bs3_pkg.sv
// Types and constants shared by the box smoothing modules.
package bs3_pkg;

    localparam int PIX_W       = 16;
    localparam int SUM_W       = 20;
    localparam int CFG_W       = 10;
    localparam int RECIP_W     = 23;
    localparam int RECIP_SHIFT = 24;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // Reciprocals scaled by 2^RECIP_SHIFT, rounded up; exact for sums below 2^20.
    localparam logic [RECIP_W-1:0] RECIP_4 = 23'd4194304;
    localparam logic [RECIP_W-1:0] RECIP_6 = 23'd2796203;
    localparam logic [RECIP_W-1:0] RECIP_9 = 23'd1864136;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pix;

    typedef struct packed {
        t_pix older;
        t_pix newer;
    } t_line;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } t_sum;

    // Clipping of the window around the pixel being smoothed.
    typedef struct packed {
        logic top;
        logic bot;
        logic has_left;
        logic has_right;
    } t_win_ctl;

    typedef enum logic [1:0] {
        DIV_4,
        DIV_6,
        DIV_9
    } t_div;

endpackage

FILE: hdl/bs3_window.sv
// Line store, sliding 3x3 window and clipped neighbourhood sums.
module bs3_window
    import bs3_pkg::*;
#(
    parameter int MAX_SIZE = 512,
    localparam int AW = $clog2(MAX_SIZE)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_pix          i_pix,
    input  t_win_ctl      i_ctl,
    output t_sum          o_sum,
    output t_div          o_div
);

    t_line mem [MAX_SIZE];
    t_line r_rd_line;
    t_line w_wr_line;
    t_pix  r_cell [6];
    t_sum  w_cur_sum;
    t_sum  w_left_sum;
    t_sum  w_right_sum;

    function automatic t_sum col_sum(input t_pix a, input t_pix b, input t_pix c,
                                     input logic top, input logic bot);
        t_sum s;
        s.red   = SUM_W'(b.red)   + (top ? SUM_W'(a.red)   : '0) + (bot ? SUM_W'(c.red)   : '0);
        s.green = SUM_W'(b.green) + (top ? SUM_W'(a.green) : '0) + (bot ? SUM_W'(c.green) : '0);
        s.blue  = SUM_W'(b.blue)  + (top ? SUM_W'(a.blue)  : '0) + (bot ? SUM_W'(c.blue)  : '0);
        return s;
    endfunction

    // write back: old newer row moves to older, the fresh pixel becomes newer
    assign w_wr_line = '{older: r_rd_line.newer, newer: i_pix};

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= w_wr_line;
        end
        if (i_rd_en) begin
            r_rd_line <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int k = 0; k < 6; k++) begin
                r_cell[k] <= '0;
            end
        end else if (i_wr_en) begin
            r_cell[3] <= r_cell[0];
            r_cell[4] <= r_cell[1];
            r_cell[5] <= r_cell[2];
            r_cell[0] <= r_rd_line.older;
            r_cell[1] <= r_rd_line.newer;
            r_cell[2] <= i_pix;
        end
    end

    always_comb begin
        w_cur_sum   = col_sum(r_cell[0], r_cell[1], r_cell[2], i_ctl.top, i_ctl.bot);
        w_left_sum  = i_ctl.has_left
                    ? col_sum(r_cell[3], r_cell[4], r_cell[5], i_ctl.top, i_ctl.bot) : '0;
        w_right_sum = i_ctl.has_right
                    ? col_sum(r_rd_line.older, r_rd_line.newer, i_pix, i_ctl.top, i_ctl.bot)
                    : '0;
        o_sum.red   = w_cur_sum.red   + w_left_sum.red   + w_right_sum.red;
        o_sum.green = w_cur_sum.green + w_left_sum.green + w_right_sum.green;
        o_sum.blue  = w_cur_sum.blue  + w_left_sum.blue  + w_right_sum.blue;
    end

    // 2 or 3 rows times 2 or 3 columns
    always_comb begin
        if ((i_ctl.top && i_ctl.bot) && (i_ctl.has_left && i_ctl.has_right)) begin
            o_div = DIV_9;
        end else if (!(i_ctl.top && i_ctl.bot) && !(i_ctl.has_left && i_ctl.has_right)) begin
            o_div = DIV_4;
        end else begin
            o_div = DIV_6;
        end
    end

endmodule

FILE: hdl/bs3_divide.sv
// Division of the window sums by 4, 6 or 9 through scaled reciprocals.
module bs3_divide
    import bs3_pkg::*;
(
    input  t_sum i_sum,
    input  t_div i_div,
    output t_pix o_pix
);

    logic [RECIP_W-1:0] w_recip;
    logic [PROD_W-1:0]  w_prod_red;
    logic [PROD_W-1:0]  w_prod_green;
    logic [PROD_W-1:0]  w_prod_blue;

    always_comb begin
        unique case (i_div)
            DIV_4:   w_recip = RECIP_4;
            DIV_6:   w_recip = RECIP_6;
            DIV_9:   w_recip = RECIP_9;
            default: w_recip = RECIP_4;
        endcase
    end

    assign w_prod_red   = PROD_W'(i_sum.red)   * PROD_W'(w_recip);
    assign w_prod_green = PROD_W'(i_sum.green) * PROD_W'(w_recip);
    assign w_prod_blue  = PROD_W'(i_sum.blue)  * PROD_W'(w_recip);

    assign o_pix.red   = w_prod_red[RECIP_SHIFT +: PIX_W];
    assign o_pix.green = w_prod_green[RECIP_SHIFT +: PIX_W];
    assign o_pix.blue  = w_prod_blue[RECIP_SHIFT +: PIX_W];

endmodule

FILE: hdl/box_smooth_3x3_core.sv
// Top level of the streaming 3x3 box smoothing filter for square RGB images.
//
// Streaming 3x3 mean filter. Send the pixels of a square image of side
// image_size in raster order, one word per pixel, then image_size+1 padding
// words whose values are ignored; the position then wraps and the next word
// starts a new frame. Each result word is one pixel replaced by the truncated
// mean of its 3x3 neighbourhood clipped to the image (4 pixels at corners,
// 6 on edges, 9 inside); o_frame_end marks the last pixel of a frame. The
// result for pixel k is triggered by the word at stream position
// k+image_size+1 and leaves through the stage A, stage B and result registers.
// The block takes one word per clock unless stalled: the line store makes one
// read and one write per cycle, the window sums sit in one register stage and
// the reciprocal multiply in the next. Back-pressure on the result side holds
// the pipeline only when a result cannot move on; words that give no result
// keep flowing. The line store needs no clearing pass: entries never written
// only reach clipped rows. Write image_size only while idle; any write
// restarts the frame. Values below 2 saturate to 2 and values above MAX_SIZE
// to MAX_SIZE.
`include "box_smooth_3x3_core_macros.svh"

module box_smooth_3x3_core
    import bs3_pkg::*;
#(
    parameter int MAX_SIZE = 512
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [PIX_W-1:0] i_in_red,
    input  logic [PIX_W-1:0] i_in_green,
    input  logic [PIX_W-1:0] i_in_blue,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [PIX_W-1:0] o_out_red,
    output logic [PIX_W-1:0] o_out_green,
    output logic [PIX_W-1:0] o_out_blue,
    output logic             o_frame_end
);

    localparam int CW         = $clog2(MAX_SIZE);
    localparam int RW         = $clog2(MAX_SIZE + 2);
    localparam int CMP_W      = (RW > CFG_W) ? RW : CFG_W;
    localparam int SIZE_RESET = (MAX_SIZE < 512) ? MAX_SIZE : 512;

    typedef struct packed {
        logic     emit;
        logic     last;
        t_win_ctl win;
    } t_item_ctl;

    // stream position and frame size
    logic [RW-1:0]    r_size;
    logic [RW-1:0]    n_size;
    logic [RW-1:0]    r_row;
    logic [RW-1:0]    n_row;
    logic [CW-1:0]    r_col;
    logic [CW-1:0]    n_col;
    logic [CMP_W-1:0] w_cfg_ext;
    logic [RW-1:0]    w_col_ext;
    logic [RW-1:0]    w_col_inc;
    logic [RW-1:0]    w_size_p1;
    logic [RW-1:0]    w_out_row;
    t_item_ctl        w_ctl;

    // stage A: accepted word, line store read in flight
    logic             r_a_valid;
    t_pix             r_a_pix;
    t_item_ctl        r_a_ctl;
    logic [CW-1:0]    r_a_col;

    // stage B: window sums
    logic             r_b_valid;
    t_sum             r_b_sum;
    t_div             r_b_div;
    logic             r_b_last;

    // result register
    logic             r_out_valid;
    t_pix             r_out_pix;
    logic             r_out_last;

    logic             w_accept;
    logic             w_out_hold;
    logic             w_b_hold;
    logic             w_a_leave;
    t_pix             w_in_pix;
    t_sum             w_sum;
    t_div             w_div;
    t_pix             w_quot;

    // Handshake: hold a stage only when its word carries a result and the
    // stage after it is held; words without a result always drain.
    assign w_out_hold = r_out_valid && i_out_stall;
    assign w_b_hold   = r_b_valid && w_out_hold;
    assign o_in_stall = r_a_valid && r_a_ctl.emit && w_b_hold;
    assign w_a_leave  = r_a_valid && !o_in_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_in_pix = '{red: i_in_red, green: i_in_green, blue: i_in_blue};

    // Saturate the written size into [2, MAX_SIZE].
    assign w_cfg_ext = CMP_W'(i_cfg_wdata);
    always_comb begin
        if (w_cfg_ext < CMP_W'(2)) begin
            n_size = RW'(2);
        end else if (w_cfg_ext > CMP_W'(MAX_SIZE)) begin
            n_size = RW'(MAX_SIZE);
        end else begin
            n_size = RW'(w_cfg_ext);
        end
    end

    assign w_col_ext = RW'(r_col);
    assign w_col_inc = w_col_ext + RW'(1);
    assign w_size_p1 = r_size + RW'(1);

    // Decide, from the position of the arriving word, which pixel (if any)
    // it completes and how that pixel's window is clipped. Mid-row words
    // finish the pixel one row up and one column left; a word at column zero
    // finishes the last pixel of the row two up.
    always_comb begin
        w_ctl     = '0;
        w_out_row = '0;
        if (w_col_ext != '0 && r_row != '0 && r_row <= r_size) begin
            w_ctl.emit          = 1'b1;
            w_out_row           = r_row - RW'(1);
            w_ctl.win.has_left  = w_col_ext >= RW'(2);
            w_ctl.win.has_right = 1'b1;
        end else if (r_col == '0 && r_row >= RW'(2)) begin
            w_ctl.emit          = 1'b1;
            w_out_row           = r_row - RW'(2);
            w_ctl.win.has_left  = 1'b1;
            w_ctl.last          = (r_row == w_size_p1);
        end
        w_ctl.win.top = (w_out_row != '0);
        w_ctl.win.bot = ((w_out_row + RW'(1)) < r_size);
    end

    // Advance the raster position; wrap after the last padding word.
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (w_ctl.last || r_row > w_size_p1) begin
            n_row = '0;
            n_col = '0;
        end else if (w_col_inc >= r_size) begin
            n_row = r_row + RW'(1);
            n_col = '0;
        end else begin
            n_col = w_col_inc[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= RW'(SIZE_RESET);
            r_row       <= '0;
            r_col       <= '0;
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_size <= n_size;
                r_row  <= '0;
                r_col  <= '0;
            end else if (w_accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (w_accept) begin
                r_a_valid <= 1'b1;
            end else if (w_a_leave) begin
                r_a_valid <= 1'b0;
            end
            if (!w_b_hold) begin
                r_b_valid <= w_a_leave && r_a_ctl.emit;
            end
            if (!w_out_hold) begin
                r_out_valid <= r_b_valid;
            end
        end
    end

    // Payload registers: load on advance, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_pix <= w_in_pix;
            r_a_ctl <= w_ctl;
            r_a_col <= r_col;
        end
        if (!w_b_hold) begin
            r_b_sum  <= w_sum;
            r_b_div  <= w_div;
            r_b_last <= r_a_ctl.last;
        end
        if (!w_out_hold) begin
            r_out_pix  <= w_quot;
            r_out_last <= r_b_last;
        end
    end

    bs3_window #(
        .MAX_SIZE (MAX_SIZE)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (i_cfg_we),
        .i_rd_en   (w_accept),
        .i_rd_addr (r_col),
        .i_wr_en   (w_a_leave),
        .i_wr_addr (r_a_col),
        .i_pix     (r_a_pix),
        .i_ctl     (r_a_ctl.win),
        .o_sum     (w_sum),
        .o_div     (w_div)
    );

    bs3_divide u_divide (
        .i_sum (r_b_sum),
        .i_div (r_b_div),
        .o_pix (w_quot)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_red   = r_out_pix.red;
    assign o_out_green = r_out_pix.green;
    assign o_out_blue  = r_out_pix.blue;
    assign o_frame_end = r_out_last;

    `BS3_ASSERT_NOW(a_stall_needs_full, o_in_stall, r_b_valid && o_out_valid && i_out_stall, "input stalled with room downstream")
    `BS3_ASSERT_NOW(a_col_in_frame, 1'b1, w_col_ext < r_size, "column position beyond image size")
    `BS3_ASSERT_NEXT(a_frame_wrap, w_accept && w_ctl.last, r_row == '0 && r_col == '0, "position did not wrap after frame end")
    `BS3_ASSERT_NEXT(a_result_kept, w_a_leave && r_a_ctl.emit && !w_b_hold, r_b_valid, "result word lost between stages")

endmodule

FILE: tb/box_smooth_3x3_checker.sv
// Checker for the 3x3 box smoothing core: predicts every smoothed pixel and compares.
`timescale 1ns / 1ps

module box_smooth_3x3_checker
    import bs3_pkg::*;
#(
    parameter int MAX_SIZE = 512
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  logic [PIX_W-1:0] i_in_red,
    input  logic [PIX_W-1:0] i_in_green,
    input  logic [PIX_W-1:0] i_in_blue,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  logic [PIX_W-1:0] i_out_red,
    input  logic [PIX_W-1:0] i_out_green,
    input  logic [PIX_W-1:0] i_out_blue,
    input  logic             i_frame_end,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);

    typedef struct packed {
        t_pix px;
        logic last;
    } t_smoothed;

    // Predictor state: two previous rows by column, two previous window columns.
    t_pix line_far  [MAX_SIZE];
    t_pix line_near [MAX_SIZE];
    t_pix col_l1    [3];
    t_pix col_l2    [3];
    int   side;
    int   pos_row;
    int   pos_col;

    t_smoothed smoothed_due [$];

    task automatic flag(input string msg);
        $display("checker: %s", msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            flag($sformatf("result %0d: %s got %0d, want %0d", o_checked, name, got, want));
        end
    endtask

    task automatic clear_window();
        for (int k = 0; k < 3; k++) begin
            col_l1[k] = '0;
            col_l2[k] = '0;
        end
        pos_row = 0;
        pos_col = 0;
    endtask

    task automatic reset_model();
        for (int i = 0; i < MAX_SIZE; i++) begin
            line_far[i]  = '0;
            line_near[i] = '0;
        end
        clear_window();
        side = MAX_SIZE;
        smoothed_due.delete();
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    endtask

    // Saturate the side length and restart the frame.
    task automatic take_size(input logic [CFG_W-1:0] wdata);
        int v;
        v = int'(wdata);
        if (v < 2) v = 2;
        if (v > MAX_SIZE) v = MAX_SIZE;
        side = v;
        clear_window();
    endtask

    task automatic smooth_word(input t_pix x);
        t_pix      here [3];
        t_pix      nbr;
        t_smoothed res;
        bit        emit, last, has_l, has_r, top, bot;
        int        r, n, sum_r, sum_g, sum_b;
        here[0] = line_far[pos_col];
        here[1] = line_near[pos_col];
        here[2] = x;
        emit  = 0;
        last  = 0;
        has_l = 0;
        has_r = 0;
        r     = 0;
        if (pos_col >= 1 && pos_row >= 1 && pos_row <= side) begin
            // Pixel one row up and one column to the left of the arriving word.
            emit  = 1;
            r     = pos_row - 1;
            has_l = (pos_col >= 2);
            has_r = 1;
        end else if (pos_col == 0 && pos_row >= 2) begin
            // Rightmost pixel of the row two above, finished by the wrap.
            emit  = 1;
            r     = pos_row - 2;
            has_l = 1;
            last  = (pos_row == side + 1);
        end
        if (emit) begin
            top   = (r >= 1);
            bot   = (r + 1 < side);
            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            n     = 0;
            for (int k = 0; k < 3; k++) begin
                if ((k != 0 || top) && (k != 2 || bot)) begin
                    for (int j = 0; j < 3; j++) begin
                        if ((j != 1 || has_l) && (j != 2 || has_r)) begin
                            nbr   = (j == 0) ? col_l1[k] : (j == 1) ? col_l2[k] : here[k];
                            sum_r += int'(nbr.red);
                            sum_g += int'(nbr.green);
                            sum_b += int'(nbr.blue);
                            n++;
                        end
                    end
                end
            end
            res.px.red   = PIX_W'(sum_r / n);
            res.px.green = PIX_W'(sum_g / n);
            res.px.blue  = PIX_W'(sum_b / n);
            res.last     = last;
            smoothed_due.push_back(res);
        end
        line_far[pos_col]  = here[1];
        line_near[pos_col] = x;
        for (int k = 0; k < 3; k++) begin
            col_l2[k] = col_l1[k];
            col_l1[k] = here[k];
        end
        if (last || pos_row > side + 1) begin
            pos_row = 0;
            pos_col = 0;
        end else begin
            pos_col++;
            if (pos_col >= side) begin
                pos_col = 0;
                pos_row++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_smoothed want;
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_cfg_we) begin
                take_size(i_cfg_wdata);
            end
            if (i_in_valid && !i_in_stall) begin
                smooth_word(t_pix'({i_in_red, i_in_green, i_in_blue}));
            end
            if (i_out_valid && !i_out_stall) begin
                if (smoothed_due.size() == 0) begin
                    flag($sformatf("result %0d arrived with nothing expected", o_checked));
                end else begin
                    want = smoothed_due.pop_front();
                    check_field("red", i_out_red, want.px.red);
                    check_field("green", i_out_green, want.px.green);
                    check_field("blue", i_out_blue, want.px.blue);
                    check_field("frame_end", i_frame_end, want.last);
                end
                o_checked++;
            end
            o_pending = smoothed_due.size();
        end
    end

endmodule

FILE: tb/tb_box_smooth_3x3_core.sv
// Testbench top for the 3x3 box smoothing core: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_box_smooth_3x3_core;
    import bs3_pkg::*;

    localparam int MAX_SIZE    = 512;
    // Allow a wide margin for words still in flight.
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 200000;
    // Word budget for the whole run.
    localparam int ITEMS       = 850;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             cfg_we      = 1'b0;
    logic [CFG_W-1:0] cfg_wdata   = '0;
    logic             in_valid    = 1'b0;
    logic [PIX_W-1:0] in_red      = '0;
    logic [PIX_W-1:0] in_green    = '0;
    logic [PIX_W-1:0] in_blue     = '0;
    logic             out_stall   = 1'b0;
    logic             in_stall;
    logic             out_valid;
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
    logic             frame_end;

    int fail_count;
    int pending;
    int checked;

    int  cycle_count = 0;
    int  words_sent  = 0;
    int  frames_sent = 0;
    bit  in_quiet    = 1'b0;
    bit  out_quiet   = 1'b0;
    bit  out_taken   = 1'b0;
    int  hold_left   = 0;

    box_smooth_3x3_core #(
        .MAX_SIZE (MAX_SIZE)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_red    (in_red),
        .i_in_green  (in_green),
        .i_in_blue   (in_blue),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_red   (out_red),
        .o_out_green (out_green),
        .o_out_blue  (out_blue),
        .o_frame_end (frame_end)
    );

    box_smooth_3x3_checker #(
        .MAX_SIZE (MAX_SIZE)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_red     (in_red),
        .i_in_green   (in_green),
        .i_in_blue    (in_blue),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_red    (out_red),
        .i_out_green  (out_green),
        .i_out_blue   (out_blue),
        .i_frame_end  (frame_end),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: stop a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
            $display("tb_box_smooth_3x3_core: FAIL");
            $finish;
        end
    end

    // Result-side back-pressure: after each accepted result, hold stall for a random hold length (none when out_quiet).
    always @(posedge i_clk) begin
        out_taken <= out_valid && !out_stall;
    end

    always @(negedge i_clk) begin
        if (out_taken) begin
            hold_left = out_quiet ? 0 : $urandom_range(0, 3);
        end
        out_stall <= (hold_left != 0);
        if (hold_left != 0) begin
            hold_left--;
        end
    end

    // Channel value biased towards the extremes so that sums hit their largest cases.
    function automatic logic [PIX_W-1:0] rand_chan();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_pix rand_pixel();
        t_pix p;
        p.red   = rand_chan();
        p.green = rand_chan();
        p.blue  = rand_chan();
        return p;
    endfunction

    // Offer one word after a random gap and hold it until accepted.
    task automatic send_word(input t_pix px);
        int gap;
        gap = in_quiet ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_red   <= px.red;
        in_green <= px.green;
        in_blue  <= px.blue;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        words_sent++;
    endtask

    // One full frame of random pixels, then side+1 padding words.
    task automatic send_frame(input int s);
        repeat (s * s) send_word(rand_pixel());
        repeat (s + 1) send_word(rand_pixel());
        frames_sent++;
    endtask

    // Drop valid and hold off until every predicted result has come out.
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Write the side length only with the pipe empty, words without results included.
    task automatic write_size(input int v);
        drain();
        repeat (SETTLE) @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= CFG_W'(v);
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        t_pix directed_px [4];
        int   s;
        int   nf;
        int   room;
        int   part;

        // Hold reset from time zero, then release it on a falling edge.
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset side is the maximum: a handful of words must give no result.
        repeat (12) send_word(rand_pixel());

        // Smallest image, every pixel at full scale: the mean must not overflow.
        write_size(2);
        repeat (4) send_word(t_pix'({16'hFFFF, 16'hFFFF, 16'hFFFF}));
        repeat (3) send_word(rand_pixel());
        frames_sent++;

        // Zero saturates to two; mixed extremes and a truncating corner sum.
        directed_px[0] = t_pix'({16'hFFFF, 16'h0000, 16'h0001});
        directed_px[1] = t_pix'({16'h0000, 16'hFFFF, 16'h0002});
        directed_px[2] = t_pix'({16'h0001, 16'hFFFF, 16'h0000});
        directed_px[3] = t_pix'({16'hFFFF, 16'h0000, 16'h0000});
        write_size(0);
        for (int i = 0; i < 4; i++) send_word(directed_px[i]);
        repeat (3) send_word(rand_pixel());
        frames_sent++;

        // All-ones write saturates to the maximum side. Stream just past the first
        // row so the column wraps at full width, pause for every result, then stop
        // part-way so the next write restarts a frame in flight.
        write_size(1023);
        in_quiet  = 1'b1;
        out_quiet = 1'b0;
        repeat (MAX_SIZE + 8) send_word(rand_pixel());
        drain();
        repeat (15) send_word(rand_pixel());

        // Random small images with random flow control and occasional broken frames;
        // shrink the side near the end so the run stays within the word budget.
        while (ITEMS - words_sent >= 7) begin
            s = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 12) : $urandom_range(2, 6);
            while (s > 2 && s * s + s + 1 > ITEMS - words_sent) s--;
            write_size(s);
            in_quiet  = ($urandom_range(0, 3) == 0);
            out_quiet = ($urandom_range(0, 3) == 0);
            nf = $urandom_range(1, 3);
            repeat (nf) begin
                if (s * s + s + 1 <= ITEMS - words_sent) begin
                    send_frame(s);
                    if ($urandom_range(0, 3) == 0) begin
                        drain();
                    end
                end
            end
            room = ITEMS - words_sent;
            if ($urandom_range(0, 1) == 1 && room > 0) begin
                part = (room < s * s + s) ? room : s * s + s;
                repeat ($urandom_range(1, part)) send_word(rand_pixel());
            end
        end

        // Let the last results through, then allow for stragglers.
        drain();
        repeat (2 * SETTLE) @(negedge i_clk);

        $display("Sent %0d words: reset side, saturating writes, a part frame at %0d, %0d frames",
                 words_sent, MAX_SIZE, frames_sent);
        $display("%0d smoothed pixels compared, %0d mismatches", checked, fail_count);
        if (fail_count == 0) begin
            $display("tb_box_smooth_3x3_core: PASS");
        end else begin
            $display("tb_box_smooth_3x3_core: FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/bs3_pkg.sv
hdl/bs3_window.sv
hdl/bs3_divide.sv
hdl/box_smooth_3x3_core.sv
tb/box_smooth_3x3_checker.sv
tb/tb_box_smooth_3x3_core.sv
